FILE: src/srs6_pkg.sv
// ----------------------------------------------------------------------------
// srs6_pkg: shared types and constants for the S6 Selling reduction block
// Component width, saturation limits, beat payload structs and the table
// that describes each reduction matrix as at most two signed terms a row.
// ----------------------------------------------------------------------------
package srs6_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int DIMS       = 6;
  localparam int IDX_W      = 3;
  localparam int STEP_W     = 8;
  localparam int TERM_W     = COMP_WIDTH + 1;
  localparam int SUM_W      = COMP_WIDTH + 2;
  localparam int EXT_W      = (COMP_WIDTH > 32) ? COMP_WIDTH : 32;

  // At full 64-bit width the negation of the most negative value saturates.
  localparam bit NEG_SAT = (COMP_WIDTH == 64);

  localparam logic [STEP_W-1:0] MAX_ITER_RESET = STEP_W'(100);

  // Register map (index into the register list).
  localparam logic REG_MAX_ITER = 1'b0;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef comp_t [DIMS-1:0] comp_vec_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] comp_in_0;
    logic signed [31:0] comp_in_1;
    logic signed [31:0] comp_in_2;
    logic signed [31:0] comp_in_3;
    logic signed [31:0] comp_in_4;
    logic signed [31:0] comp_in_5;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] comp_out_0;
    logic signed [31:0] comp_out_1;
    logic signed [31:0] comp_out_2;
    logic signed [31:0] comp_out_3;
    logic signed [31:0] comp_out_4;
    logic signed [31:0] comp_out_5;
    logic               fully_reduced;
    logic [STEP_W-1:0]  steps_taken;
  } out_beat_t;

  // One row of a reduction matrix: first term, optional second term.
  typedef struct packed {
    logic [IDX_W-1:0] col_a;
    logic             neg_a;
    logic             use_b;
    logic [IDX_W-1:0] col_b;
    logic             neg_b;
  } row_term_t;

  function automatic row_term_t t2(int ca, bit na, int cb, bit nb);
    row_term_t r;
    r.col_a = IDX_W'(ca);
    r.neg_a = na;
    r.use_b = 1'b1;
    r.col_b = IDX_W'(cb);
    r.neg_b = nb;
    return r;
  endfunction

  function automatic row_term_t t1(int ca);
    row_term_t r;
    r.col_a = IDX_W'(ca);
    r.neg_a = 1'b1;
    r.use_b = 1'b0;
    r.col_b = '0;
    r.neg_b = 1'b0;
    return r;
  endfunction

  // RED_TERMS[idx][row]: each row is a sum of one or two signed components.
  localparam row_term_t RED_TERMS [DIMS][DIMS] = '{
    '{t1(0), t2(0,0,1,0), t2(0,0,4,0), t2(0,1,3,0), t2(0,0,2,0), t2(0,0,5,0)},
    '{t2(0,0,1,0), t1(1), t2(1,0,3,0), t2(1,0,2,0), t2(1,1,4,0), t2(1,0,5,0)},
    '{t2(0,0,2,0), t2(2,0,3,0), t1(2), t2(1,0,2,0), t2(2,0,4,0), t2(2,1,5,0)},
    '{t2(0,0,3,1), t2(2,0,3,0), t2(1,0,3,0), t1(3), t2(3,0,4,0), t2(3,0,5,0)},
    '{t2(2,0,4,0), t2(1,0,4,1), t2(0,0,4,0), t2(3,0,4,0), t1(4), t2(4,0,5,0)},
    '{t2(1,0,5,0), t2(0,0,5,0), t2(2,0,5,1), t2(3,0,5,0), t2(4,0,5,0), t1(5)}
  };

  // Sign-extend a 32-bit input component and clamp it to the component range.
  function automatic comp_t to_comp(logic signed [31:0] x);
    logic signed [EXT_W-1:0] xe;
    comp_t r;
    xe = EXT_W'(x);
    if (xe > EXT_W'(COMP_MAX)) begin
      r = COMP_MAX;
    end else if (xe < EXT_W'(COMP_MIN)) begin
      r = COMP_MIN;
    end else begin
      r = COMP_WIDTH'(xe);
    end
    return r;
  endfunction

  function automatic logic signed [TERM_W-1:0] term_val(comp_t v, logic neg);
    logic signed [TERM_W-1:0] e;
    e = TERM_W'($signed(v));
    if (neg) begin
      e = -e;
    end
    if (NEG_SAT && (e > TERM_W'(COMP_MAX))) begin
      e = TERM_W'(COMP_MAX);
    end
    return e;
  endfunction

  function automatic comp_t row_sum(comp_vec_t v, row_term_t t);
    logic signed [TERM_W-1:0] a;
    logic signed [TERM_W-1:0] b;
    logic signed [SUM_W-1:0]  s;
    comp_t r;
    a = term_val(v[t.col_a], t.neg_a);
    b = t.use_b ? term_val(v[t.col_b], t.neg_b) : '0;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(COMP_MAX)) begin
      r = COMP_MAX;
    end else if (s < SUM_W'(COMP_MIN)) begin
      r = COMP_MIN;
    end else begin
      r = COMP_WIDTH'(s);
    end
    return r;
  endfunction

endpackage

FILE: src/selling_reduction_s6.sv
// ----------------------------------------------------------------------------
// selling_reduction_s6: iterative Selling reduction of one S6 vector
// Repeats reduction steps on a signed Q16.16 vector until no component is
// positive or the step limit in max_iterations is reached.
// ----------------------------------------------------------------------------
// One vector is accepted while the block is idle. A single step unit then
// applies one reduction matrix per clock cycle to the held vector until it
// finds the vector reduced or the limit reached, and then moves the result
// into the output register. No new vector is taken while a run is going on.
// The result waits in the output register, so the next vector can be taken
// while the previous beat is still stalled; a vector only holds in its final
// cycle when the output register is still occupied.
module selling_reduction_s6
  import srs6_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   max_iterations;
  logic [STEP_W-1:0]   steps;
  comp_vec_t           cur;
  comp_vec_t           in_vec;
  comp_vec_t           step_vec;
  logic [IDX_W-1:0]    pos_idx;
  logic                pos_any;
  logic                accept;
  logic                finish;
  logic                out_free;
  logic                do_step;
  logic                do_load;
  logic                cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_ITER) ? {{(32-STEP_W){1'b0}}, max_iterations} : '0;

  assign in_vec[0] = to_comp(in_data.comp_in_0);
  assign in_vec[1] = to_comp(in_data.comp_in_1);
  assign in_vec[2] = to_comp(in_data.comp_in_2);
  assign in_vec[3] = to_comp(in_data.comp_in_3);
  assign in_vec[4] = to_comp(in_data.comp_in_4);
  assign in_vec[5] = to_comp(in_data.comp_in_5);

  // Lowest-indexed strictly positive component of the held vector.
  always_comb begin
    pos_any = 1'b0;
    pos_idx = '0;
    for (int i = DIMS - 1; i >= 0; i--) begin
      if (!cur[i][COMP_WIDTH-1] && (|cur[i])) begin
        pos_any = 1'b1;
        pos_idx = IDX_W'(i);
      end
    end
  end

  // Step unit: each new component is one saturating sum of one or two terms.
  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      step_vec[r] = row_sum(cur, RED_TERMS[pos_idx][r]);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign finish   = !pos_any || (steps == max_iterations);
  assign out_free = !out_valid || !out_stall;
  assign do_step  = (state == S_RUN) && !finish;
  assign do_load  = (state == S_RUN) && finish && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (do_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      steps          <= '0;
      out_valid      <= 1'b0;
      max_iterations <= MAX_ITER_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr && (paddr[2] == REG_MAX_ITER)) begin
        max_iterations <= pwdata[STEP_W-1:0];
      end
      if (accept) begin
        steps <= '0;
      end else if (do_step) begin
        steps <= steps + STEP_W'(1);
      end
      if (do_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= in_vec;
    end else if (do_step) begin
      cur <= step_vec;
    end
    if (do_load) begin
      out_data.comp_out_0    <= 32'(cur[0]);
      out_data.comp_out_1    <= 32'(cur[1]);
      out_data.comp_out_2    <= 32'(cur[2]);
      out_data.comp_out_3    <= 32'(cur[3]);
      out_data.comp_out_4    <= 32'(cur[4]);
      out_data.comp_out_5    <= 32'(cur[5]);
      out_data.fully_reduced <= !pos_any;
      out_data.steps_taken   <= steps;
    end
  end

`ifndef SYNTHESIS
  // A new vector always starts a run with a cleared step count.
  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN) && (steps == '0))
    else $error("accepted vector did not start a fresh run");

  // Each applied step advances the count by exactly one.
  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    do_step |=> (steps == $past(steps) + STEP_W'(1)) && (state == S_RUN))
    else $error("reduction step not counted");

  // A vector with no positive component is delivered flagged as reduced.
  a_reduced_flag: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RUN) && !pos_any && out_free) |=> out_valid && out_data.fully_reduced)
    else $error("reduced vector not delivered as reduced");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the S6 Selling reduction block
// Feeds Q16.16 vectors through a valid/stall driver, predicts each reduced
// vector with a behavioral copy of the reduction steps, and checks every
// output beat field by field across several step-limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  import srs6_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 40;
  localparam logic [2:0] ITER_ADDR = 3'(4 * int'(REG_MAX_ITER));
  localparam longint COMP_HI = 64'sd2147483647;
  localparam longint COMP_LO = -64'sd2147483648;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  // Reduction matrices, indexed by [first positive component][row][column].
  localparam int REDUCE_MAT [6][6][6] = '{
    '{'{-1, 0, 0, 0, 0, 0}, '{ 1, 1, 0, 0, 0, 0}, '{ 1, 0, 0, 0, 1, 0},
      '{-1, 0, 0, 1, 0, 0}, '{ 1, 0, 1, 0, 0, 0}, '{ 1, 0, 0, 0, 0, 1}},
    '{'{ 1, 1, 0, 0, 0, 0}, '{ 0,-1, 0, 0, 0, 0}, '{ 0, 1, 0, 1, 0, 0},
      '{ 0, 1, 1, 0, 0, 0}, '{ 0,-1, 0, 0, 1, 0}, '{ 0, 1, 0, 0, 0, 1}},
    '{'{ 1, 0, 1, 0, 0, 0}, '{ 0, 0, 1, 1, 0, 0}, '{ 0, 0,-1, 0, 0, 0},
      '{ 0, 1, 1, 0, 0, 0}, '{ 0, 0, 1, 0, 1, 0}, '{ 0, 0,-1, 0, 0, 1}},
    '{'{ 1, 0, 0,-1, 0, 0}, '{ 0, 0, 1, 1, 0, 0}, '{ 0, 1, 0, 1, 0, 0},
      '{ 0, 0, 0,-1, 0, 0}, '{ 0, 0, 0, 1, 1, 0}, '{ 0, 0, 0, 1, 0, 1}},
    '{'{ 0, 0, 1, 0, 1, 0}, '{ 0, 1, 0, 0,-1, 0}, '{ 1, 0, 0, 0, 1, 0},
      '{ 0, 0, 0, 1, 1, 0}, '{ 0, 0, 0, 0,-1, 0}, '{ 0, 0, 0, 0, 1, 1}},
    '{'{ 0, 1, 0, 0, 0, 1}, '{ 1, 0, 0, 0, 0, 1}, '{ 0, 0, 1, 0, 0,-1},
      '{ 0, 0, 0, 1, 0, 1}, '{ 0, 0, 0, 0, 1, 1}, '{ 0, 0, 0, 0, 0,-1}}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  in_beat_t    vec_queue[$];
  out_beat_t   reduced_queue[$];
  logic [7:0]  iter_limit = MAX_ITER_RESET;
  int          mismatches;
  int          quiet_cycles;
  int          beats_in;
  int          gap_left;
  int          stall_left;
  bit          in_took;
  bit          hold_on;
  bit          calm;

  selling_reduction_s6 i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic int lead_positive(input longint v [6]);
    for (int i = 0; i < 6; i++) begin
      if (v[i] > 0) return i;
    end
    return -1;
  endfunction

  // Applies reduction steps until no component is positive or the limit is hit.
  function automatic out_beat_t selling_reduce(input in_beat_t vin, input logic [7:0] lim);
    longint v [6];
    longint nv [6];
    longint acc;
    int idx;
    int steps;
    out_beat_t r;
    v[0] = longint'($signed(vin.comp_in_0));
    v[1] = longint'($signed(vin.comp_in_1));
    v[2] = longint'($signed(vin.comp_in_2));
    v[3] = longint'($signed(vin.comp_in_3));
    v[4] = longint'($signed(vin.comp_in_4));
    v[5] = longint'($signed(vin.comp_in_5));
    steps = 0;
    idx = lead_positive(v);
    while (steps < int'(lim) && idx >= 0) begin
      for (int i = 0; i < 6; i++) begin
        acc = 0;
        for (int j = 0; j < 6; j++) begin
          if (REDUCE_MAT[idx][i][j] > 0) acc += v[j];
          else if (REDUCE_MAT[idx][i][j] < 0) acc -= v[j];
        end
        if (acc > COMP_HI) acc = COMP_HI;
        else if (acc < COMP_LO) acc = COMP_LO;
        nv[i] = acc;
      end
      v = nv;
      steps++;
      idx = lead_positive(v);
    end
    r.comp_out_0    = 32'(v[0]);
    r.comp_out_1    = 32'(v[1]);
    r.comp_out_2    = 32'(v[2]);
    r.comp_out_3    = 32'(v[3]);
    r.comp_out_4    = 32'(v[4]);
    r.comp_out_5    = 32'(v[5]);
    r.fully_reduced = (idx < 0);
    r.steps_taken   = 8'(steps);
    return r;
  endfunction

  function automatic int pick_idle();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [31:0] rand_comp();
    logic signed [31:0] x;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: x = 32'sh7FFF_FFFF;
          1: x = 32'sh8000_0000;
          2: x = '0;
          3: x = 32'sd1;
          default: x = -32'sd1;
        endcase
      end
      1, 2, 3, 4: x = $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
      default: x = $urandom();
    endcase
    return x;
  endfunction

  // Half the vectors look like real Selling input: nonpositive apart from one or
  // two components. The rest are already reduced or fully random.
  function automatic in_beat_t rand_vec();
    logic signed [31:0] c [6];
    int kind;
    int p;
    kind = $urandom_range(9);
    for (int i = 0; i < 6; i++) begin
      c[i] = rand_comp();
    end
    if (kind < 7) begin
      for (int i = 0; i < 6; i++) begin
        if (c[i] > 0) c[i] = ~c[i];
      end
    end
    if (kind < 5) begin
      p = $urandom_range(5);
      c[p] = ~c[p];
      if (kind < 2) begin
        p = $urandom_range(5);
        c[p] = ~c[p];
      end
    end
    return in_beat_t'{c[0], c[1], c[2], c[3], c[4], c[5]};
  endfunction

  task automatic push_vec(input logic signed [31:0] a, b, c, d, e, f);
    vec_queue = {vec_queue, in_beat_t'{a, b, c, d, e, f}};
  endtask

  // Writes the step limit, then reads it back.
  task automatic set_iter_limit(input logic [7:0] lim);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ITER_ADDR;
    pwdata  <= 32'(lim);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(lim)) begin
      report_mismatch($sformatf("max_iterations read %h, want %h", prdata, 32'(lim)));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    iter_limit = lim;
  endtask

  task automatic run_random(input int count);
    repeat (count) vec_queue = {vec_queue, rand_vec()};
    while (vec_queue.size() != 0 || reduced_queue.size() != 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  // Input driver.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (vec_queue.size() != 0) begin
        in_data  <= vec_queue.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern; the long hold-off overrides it.
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(3) == 0) stall_left = pick_idle();
    out_stall <= hold_on || (stall_left > 0);
  end

  // Monitor: checks output beats and records the expected reduction of each
  // accepted input beat.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    bit moved;
    moved = 1'b0;
    in_took = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      moved = 1'b1;
      if (reduced_queue.size() == 0) begin
        report_mismatch("output beat with no vector outstanding");
      end else begin
        want = reduced_queue.pop_front();
        if (out_data.comp_out_0 !== want.comp_out_0)
          report_mismatch($sformatf("comp_out_0 %h, want %h", out_data.comp_out_0, want.comp_out_0));
        if (out_data.comp_out_1 !== want.comp_out_1)
          report_mismatch($sformatf("comp_out_1 %h, want %h", out_data.comp_out_1, want.comp_out_1));
        if (out_data.comp_out_2 !== want.comp_out_2)
          report_mismatch($sformatf("comp_out_2 %h, want %h", out_data.comp_out_2, want.comp_out_2));
        if (out_data.comp_out_3 !== want.comp_out_3)
          report_mismatch($sformatf("comp_out_3 %h, want %h", out_data.comp_out_3, want.comp_out_3));
        if (out_data.comp_out_4 !== want.comp_out_4)
          report_mismatch($sformatf("comp_out_4 %h, want %h", out_data.comp_out_4, want.comp_out_4));
        if (out_data.comp_out_5 !== want.comp_out_5)
          report_mismatch($sformatf("comp_out_5 %h, want %h", out_data.comp_out_5, want.comp_out_5));
        if (out_data.fully_reduced !== want.fully_reduced)
          report_mismatch($sformatf("fully_reduced %b, want %b",
                                    out_data.fully_reduced, want.fully_reduced));
        if (out_data.steps_taken !== want.steps_taken)
          report_mismatch($sformatf("steps_taken %0d, want %0d",
                                    out_data.steps_taken, want.steps_taken));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      moved = 1'b1;
      in_took = 1'b1;
      beats_in++;
      reduced_queue = {reduced_queue, selling_reduce(in_data, iter_limit)};
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Long output hold-off so the block fills and stalls its input.
  initial begin
    while (beats_in < 40) @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_CYCLES);
    $display("selling_reduction_s6: mismatch");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limit: extremes, each reduction matrix, saturating sums.
    push_vec('0, '0, '0, '0, '0, '0);
    push_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_vec(-1, -1, -1, -1, -1, -1);
    for (int i = 0; i < 6; i++) begin
      push_vec(i == 0 ? ONE_Q : -3 * ONE_Q, i == 1 ? ONE_Q : -3 * ONE_Q,
               i == 2 ? ONE_Q : -3 * ONE_Q, i == 3 ? ONE_Q : -3 * ONE_Q,
               i == 4 ? ONE_Q : -3 * ONE_Q, i == 5 ? ONE_Q : -3 * ONE_Q);
    end
    push_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, '0, '0);
    push_vec(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_vec(1, -1, -1, -1, -1, -1);
    push_vec(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
             32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    push_vec(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
             32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
    push_vec(-ONE_Q, -2 * ONE_Q, -32'sh8000, -32'sh18000, -3 * ONE_Q, 32'sh4000);
    run_random(250);

    // Zero limit: vectors come back untouched.
    set_iter_limit(8'd0);
    push_vec(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q);
    push_vec(-ONE_Q, ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q);
    run_random(60);

    calm = 1'b1;
    set_iter_limit(8'd255);
    run_random(200);
    calm = 1'b0;

    // One step: reduced exactly at the limit, and still unreduced.
    set_iter_limit(8'd1);
    push_vec(ONE_Q, -5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q);
    push_vec(ONE_Q, ONE_Q, -5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q);
    run_random(80);

    set_iter_limit(8'($urandom_range(30, 2)));
    run_random(150);

    set_iter_limit(8'($urandom_range(254, 31)));
    run_random(190);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("selling_reduction_s6: match");
    end else begin
      $display("selling_reduction_s6: mismatch");
    end
    $finish;
  end

endmodule
